@@ rtl/supt_pkg.sv @@
package supt_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int GRP_SIZE    = 8;
  localparam int NGRP        = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_ENTRIES = NGRP * GRP_SIZE;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 32;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_REG  = 2'd0,
    CMD_REM  = 2'd1,
    CMD_FIND = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_DUP      = 3'd2,
    ST_CONFLICT = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    cmp;
    logic    red;
    logic    commit;
    logic    ins;
    logic    rem;
    logic    find_ok;
    status_t status;
  } supt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] req_cmd;
    logic             id_zero;
    logic             key_zero;
    logic             id_hit;
    logic             pair_hit;
    logic             key_hit;
    logic             full;
  } supt_flags_t;

endpackage

@@ rtl/supt_if.sv @@
interface supt_in_if;
  logic                        valid;
  logic                        ready;
  logic [supt_pkg::CMD_W-1:0]  command;
  logic [supt_pkg::ID_W-1:0]   player_id;
  logic [supt_pkg::KEY_W-1:0]  entity_key;

  modport source (output valid, output command, output player_id, output entity_key,
                  input ready);
  modport sink   (input valid, input command, input player_id, input entity_key,
                  output ready);
endinterface

interface supt_out_if;
  logic                          valid;
  logic                          ready;
  logic [supt_pkg::STATUS_W-1:0] status;
  logic [supt_pkg::KEY_W-1:0]    found_key;
  logic [supt_pkg::TOTAL_W-1:0]  entry_total;

  modport source (output valid, output status, output found_key, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input found_key, input entry_total,
                  output ready);
endinterface

@@ rtl/supt_ctrl.sv @@
module supt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  supt_pkg::supt_flags_t flags,
  output supt_pkg::supt_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_RED  = 4'b0100,
    S_DEC  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Commit only once the result register is free or being drained
  assign go = (state_r == S_DEC) && (!out_valid_r || out_ready);

  // Decide the outcome from the reduced compare flags
  always_comb begin
    cmd         = '0;
    cmd.status  = supt_pkg::ST_INVALID;
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.cmp     = (state_r == S_CMP);
    cmd.red     = (state_r == S_RED);
    cmd.commit  = go;
    case (supt_pkg::cmd_t'(flags.req_cmd))
      supt_pkg::CMD_REG: begin
        if (flags.id_zero || flags.key_zero) begin
          cmd.status = supt_pkg::ST_INVALID;
        end else if (flags.id_hit) begin
          cmd.status = flags.pair_hit ? supt_pkg::ST_DUP : supt_pkg::ST_CONFLICT;
        end else if (flags.key_hit) begin
          cmd.status = supt_pkg::ST_CONFLICT;
        end else if (flags.full) begin
          cmd.status = supt_pkg::ST_FULL;
        end else begin
          cmd.status = supt_pkg::ST_OK;
          cmd.ins    = go;
        end
      end
      supt_pkg::CMD_REM: begin
        if (flags.id_zero || flags.key_zero) begin
          cmd.status = supt_pkg::ST_INVALID;
        end else if (flags.pair_hit) begin
          cmd.status = supt_pkg::ST_OK;
          cmd.rem    = go;
        end else begin
          cmd.status = supt_pkg::ST_NOTFOUND;
        end
      end
      supt_pkg::CMD_FIND: begin
        if (flags.id_zero) begin
          cmd.status = supt_pkg::ST_INVALID;
        end else if (flags.id_hit) begin
          cmd.status  = supt_pkg::ST_OK;
          cmd.find_ok = 1'b1;
        end else begin
          cmd.status = supt_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        cmd.status = supt_pkg::ST_INVALID;
      end
    endcase
  end

  // Advance through compare, reduce and decide
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_RED;
      S_RED:  state_nxt = S_DEC;
      S_DEC: begin
        if (go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/supt_dp.sv @@
module supt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [supt_pkg::CMD_W-1:0]     in_command,
  input  logic [supt_pkg::ID_W-1:0]      in_player_id,
  input  logic [supt_pkg::KEY_W-1:0]     in_entity_key,
  input  supt_pkg::supt_cmd_t            cmd,
  output supt_pkg::supt_flags_t          flags,
  output logic [supt_pkg::STATUS_W-1:0]  out_status,
  output logic [supt_pkg::KEY_W-1:0]     out_found_key,
  output logic [supt_pkg::TOTAL_W-1:0]   out_entry_total
);

  localparam int N = supt_pkg::MAX_ENTRIES;
  localparam int G = supt_pkg::GRP_SIZE;

  // Latched request
  logic [supt_pkg::CMD_W-1:0] req_cmd_r;
  logic [supt_pkg::ID_W-1:0]  req_id_r;
  logic [supt_pkg::KEY_W-1:0] req_key_r;

  // Sorted entry row and fill count
  logic [supt_pkg::ID_W-1:0]  id_cell_r  [N];
  logic [supt_pkg::KEY_W-1:0] key_cell_r [N];
  logic [supt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Per-entry compare results, padded to whole groups
  logic [N-1:0]                    lt_r, ideq_r, keyeq_r;
  logic [supt_pkg::PAD_ENTRIES-1:0] ideq_pad, pair_pad, keyeq_pad;
  logic [supt_pkg::KEY_W-1:0]      key_pad [supt_pkg::PAD_ENTRIES];

  // Group reduction registers
  logic [supt_pkg::NGRP-1:0]  grp_id_r, grp_pair_r, grp_key_r;
  logic [supt_pkg::KEY_W-1:0] grp_fkey_r [supt_pkg::NGRP];
  logic [supt_pkg::KEY_W-1:0] fkey;

  // Result register
  logic [supt_pkg::STATUS_W-1:0] out_status_r;
  logic [supt_pkg::KEY_W-1:0]    out_key_r;
  logic [supt_pkg::TOTAL_W-1:0]  out_total_r;

  // Hold the request from its transfer until the next one
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r <= in_command;
      req_id_r  <= in_player_id;
      req_key_r <= in_entity_key;
    end
  end

  // Compare every live entry against the request, then open or close a gap
  for (genvar i = 0; i < N; i++) begin : g_entry
    logic live;
    logic [supt_pkg::ID_W-1:0]  id_nxt;
    logic [supt_pkg::KEY_W-1:0] key_nxt;

    assign live = (supt_pkg::CNT_W'(i) < cnt_r);

    always_ff @(posedge clk) begin
      if (cmd.cmp) begin
        lt_r[i]    <= live && (id_cell_r[i] < req_id_r);
        ideq_r[i]  <= live && (id_cell_r[i] == req_id_r);
        keyeq_r[i] <= live && (key_cell_r[i] == req_key_r);
      end
    end

    always_comb begin
      id_nxt  = id_cell_r[i];
      key_nxt = key_cell_r[i];
      if (cmd.ins && !lt_r[i]) begin
        id_nxt  = req_id_r;
        key_nxt = req_key_r;
      end
    end

    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.ins && !lt_r[i]) begin
          id_cell_r[i]  <= id_nxt;
          key_cell_r[i] <= key_nxt;
        end else if (cmd.rem && !lt_r[i] && N > 1) begin
          id_cell_r[i]  <= id_cell_r[(i + 1) % N];
          key_cell_r[i] <= key_cell_r[(i + 1) % N];
        end
      end
    end else if (i == N - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.ins && !lt_r[i]) begin
          id_cell_r[i]  <= lt_r[i-1] ? id_nxt  : id_cell_r[i-1];
          key_cell_r[i] <= lt_r[i-1] ? key_nxt : key_cell_r[i-1];
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.ins && !lt_r[i]) begin
          id_cell_r[i]  <= lt_r[i-1] ? id_nxt  : id_cell_r[i-1];
          key_cell_r[i] <= lt_r[i-1] ? key_nxt : key_cell_r[i-1];
        end else if (cmd.rem && !lt_r[i]) begin
          id_cell_r[i]  <= id_cell_r[i+1];
          key_cell_r[i] <= key_cell_r[i+1];
        end
      end
    end
  end

  // Pad the compare vectors up to whole groups
  for (genvar i = 0; i < supt_pkg::PAD_ENTRIES; i++) begin : g_pad
    if (i < N) begin : g_real
      assign ideq_pad[i]  = ideq_r[i];
      assign pair_pad[i]  = ideq_r[i] && keyeq_r[i];
      assign keyeq_pad[i] = keyeq_r[i];
      assign key_pad[i]   = key_cell_r[i];
    end else begin : g_fill
      assign ideq_pad[i]  = 1'b0;
      assign pair_pad[i]  = 1'b0;
      assign keyeq_pad[i] = 1'b0;
      assign key_pad[i]   = '0;
    end
  end

  // Reduce each group of entries into one register
  for (genvar g = 0; g < supt_pkg::NGRP; g++) begin : g_grp
    logic [supt_pkg::KEY_W-1:0] fkey_g;

    always_comb begin
      fkey_g = '0;
      for (int j = 0; j < G; j++) begin
        fkey_g = fkey_g | (ideq_pad[g*G + j] ? key_pad[g*G + j] : '0);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.red) begin
        grp_id_r[g]   <= |ideq_pad[g*G +: G];
        grp_pair_r[g] <= |pair_pad[g*G +: G];
        grp_key_r[g]  <= |keyeq_pad[g*G +: G];
        grp_fkey_r[g] <= fkey_g;
      end
    end
  end

  // Final OR across groups
  always_comb begin
    fkey = '0;
    for (int g = 0; g < supt_pkg::NGRP; g++) begin
      fkey = fkey | grp_fkey_r[g];
    end
  end

  assign flags.req_cmd  = req_cmd_r;
  assign flags.id_zero  = (req_id_r == '0);
  assign flags.key_zero = (req_key_r == '0);
  assign flags.id_hit   = |grp_id_r;
  assign flags.pair_hit = |grp_pair_r;
  assign flags.key_hit  = |grp_key_r;
  assign flags.full     = (cnt_r == supt_pkg::CNT_W'(N));

  // Count follows the committed insert or removal
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Capture the result on commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= cmd.status;
      out_key_r    <= cmd.find_ok ? fkey : '0;
      out_total_r  <= supt_pkg::TOTAL_W'(cnt_nxt);
    end
  end

  assign out_status      = out_status_r;
  assign out_found_key   = out_key_r;
  assign out_entry_total = out_total_r;

endmodule

@@ rtl/sorted_unique_pair_table_core.sv @@
// Channel   Dir  Payload                                Transfer
// in_chan   in   command, player_id, entity_key          valid && ready
// out_chan  out  status, found_key, entry_total          valid && ready
//
// Each command goes through transfer, parallel compare of all entries, grouped
// reduction, then decide; an insert or removal shifts the row by one place.
// The compare and reduce steps are registered to cut the entry row path.
// A result waits in the output register; the next command is taken meanwhile
// and holds in its decide step until that register drains.
// rst_n is synchronous and empties the table; entry contents need no reset.
module sorted_unique_pair_table_core (
  input logic         clk,
  input logic         rst_n,
  supt_in_if.sink     in_chan,
  supt_out_if.source  out_chan
);

  supt_pkg::supt_cmd_t   cmd;
  supt_pkg::supt_flags_t flags;

  supt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  supt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_chan.command),
    .in_player_id    (in_chan.player_id),
    .in_entity_key   (in_chan.entity_key),
    .cmd             (cmd),
    .flags           (flags),
    .out_status      (out_chan.status),
    .out_found_key   (out_chan.found_key),
    .out_entry_total (out_chan.entry_total)
  );

endmodule

@@ rtl/supt_checker.sv @@
module supt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [supt_pkg::STATUS_W-1:0] out_status,
  input logic [supt_pkg::KEY_W-1:0]    out_found_key,
  input logic [supt_pkg::TOTAL_W-1:0]  out_entry_total
);

  logic                         in_xfer, out_xfer;
  logic [1:0]                   pend_r, pend_nxt;
  logic [supt_pkg::TOTAL_W-1:0] last_total_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Track commands taken but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      last_total_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_xfer) begin
        last_total_r <= out_entry_total;
      end
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_key) && $stable(out_entry_total))
    else $error("result changed while stalled");

  // Every result answers a command, and at most two are outstanding
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pend_r != 2'd0)
    else $error("result without a command");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> pend_r <= 2'd1)
    else $error("too many commands outstanding");

  // Entry total moves by at most one per command
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_entry_total == last_total_r ||
      out_entry_total == last_total_r + 1'b1 ||
      out_entry_total == last_total_r - 1'b1)
    else $error("entry total jumped");

  // A key is only reported with a good status
  a_key_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_key != '0 |-> out_status == supt_pkg::ST_OK)
    else $error("key reported on failure");

endmodule

bind sorted_unique_pair_table_core supt_checker u_supt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_found_key   (out_chan.found_key),
  .out_entry_total (out_chan.entry_total)
);
